/* hw/rtl/pes_header_parser_assert.svh */
// assertion macros for the pes header parser
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef PES_HEADER_PARSER_ASSERT_SVH
`define PES_HEADER_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PES_ASSERT_IMPLY(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("pes header parser: implication failed");
`define PES_ASSERT_NEXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("pes header parser: next-cycle check failed");
`else
`define PES_ASSERT_IMPLY(lbl, ck, rs, a, b)
`define PES_ASSERT_NEXT(lbl, ck, rs, a, b)
`endif
`endif

/* hw/rtl/pes_hdr_pkg.sv */
// shared types and constants for the pes header parser
// no dependencies
package pes_hdr_pkg;

  typedef enum logic [1:0] {
    ID_NONE,
    ID_SIMPLE,
    ID_COMPLEX
  } id_class_t;

  localparam logic [0:0] CFG_VIDEO = 1'd0;
  localparam logic [0:0] CFG_AUDIO = 1'd1;
  localparam logic [7:0] VIDEO_ID_RESET = 8'hE0;
  localparam logic [7:0] AUDIO_ID_RESET = 8'hC0;
  localparam logic [23:0] START_PREFIX = 24'h000001;
  localparam logic [7:0] FIRST_PES_ID = 8'hBB;

  // stream id classification by the fixed range table
  function automatic id_class_t id_class(input logic [7:0] id);
    id_class_t c;
    if (id < FIRST_PES_ID) c = ID_NONE;
    else if (id == 8'hBD || (id >= 8'hC0 && id <= 8'hEF) ||
             (id >= 8'hF3 && id <= 8'hF7) || id == 8'hF9) c = ID_COMPLEX;
    else c = ID_SIMPLE;
    return c;
  endfunction

endpackage

/* hw/rtl/pes_header_parser.sv */
// pes header parser top level: start code scan, header capture, extension walk
// depends on pes_hdr_pkg and pes_header_parser_assert.svh
//
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   stream_byte
// out      out  out_valid/out_stall header record fields
// cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// scan, collect and skip take one word per cycle while in_stall is low.
// the extension walk at header end reads the header memory through its single
// registered port: flags bytes step through FRD, FLAG and POST, private section
// bytes through URD and UUSE, and DONE hands out the record.
// in_stall is high during the walk, and while collecting when a record is stalled.
// rst is synchronous; header memory is not cleared.
`include "pes_header_parser_assert.svh"
module pes_header_parser #(
  parameter int HEADER_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  stream_id,
  output logic        packet_kind,
  output logic [15:0] pes_length,
  output logic [8:0]  header_length,
  output logic [1:0]  scramble_bits,
  output logic        mark_bad,
  output logic        encrypted,
  output logic        key_found,
  output logic [23:0] block_number,
  output logic [31:0] check_word,
  output logic [2:0]  marker_errors,
  output logic        header_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW = $clog2(HEADER_BYTES);
  localparam int OW = $clog2(HEADER_BYTES) + 2;
  localparam logic [8:0] HB9 = 9'(HEADER_BYTES);

  typedef enum logic [3:0] {
    S_SCAN, S_COLLECT, S_SKIP, S_FRD, S_FLAG, S_URD, S_UUSE, S_POST, S_DONE
  } state_t;

  state_t      state;
  logic [31:0] marker;
  logic [7:0]  cur_id;
  logic [8:0]  byte_index;
  logic [16:0] skip_count;
  logic [7:0]  video_id, audio_id;
  logic [7:0]  len_hi, len_lo, flg2, flg3, hl4;
  logic [OW-1:0] flg_at, at;
  logic [3:0]  k;
  logic [7:0]  flag;
  logic        found;
  logic [23:0] blk;
  logic [31:0] chk;
  logic [2:0]  errs;

  logic [7:0]  hdr_mem [HEADER_BYTES];
  logic [7:0]  rdata;
  logic        rd_ok;
  logic [OW-1:0] rd_ofs;

  logic        accept, out_busy, walking;
  logic [31:0] shifted;
  logic [8:0]  n, hlen_now, hlen_reg;
  logic [15:0] len_now;
  logic [16:0] total;
  logic [7:0]  p;
  logic [1:0]  scr_now;
  logic        enc_now;
  logic [OW-1:0] at_a, at_b;

  assign cfg_ready = 1'b1;
  assign walking = (state == S_FRD) || (state == S_FLAG) || (state == S_URD) ||
                   (state == S_UUSE) || (state == S_POST) || (state == S_DONE);
  assign out_busy = out_valid && out_stall;
  assign in_stall = walking || (out_busy && state == S_COLLECT);
  assign accept = in_valid && !in_stall;

  // datapath helpers
  assign shifted = {marker[23:0], stream_byte};
  assign n = byte_index + 9'd1;
  assign hlen_now = 9'd5 + {1'b0, stream_byte};
  assign hlen_reg = 9'd5 + {1'b0, hl4};
  assign len_now = (byte_index == 9'd1) ? {len_hi, stream_byte} : {len_hi, len_lo};
  assign total = {1'b0, len_now} + 17'd2;
  assign scr_now = flg2[5:4];
  assign enc_now = (cur_id == video_id || cur_id == audio_id) && scr_now == 2'b11;
  assign p = rd_ok ? rdata : 8'h00;
  assign at_a = at + (p[5] ? OW'(4) : OW'(0));
  assign at_b = at + (flag[4] ? OW'(2) : OW'(0));
  assign rd_ofs = (state == S_FRD) ? flg_at : at + OW'(k);

  // header memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (accept && state == S_COLLECT && byte_index < HB9)
      hdr_mem[byte_index[AW-1:0]] <= stream_byte;
    rdata <= hdr_mem[rd_ofs[AW-1:0]];
    rd_ok <= rd_ofs < OW'(hlen_reg);
  end

  // control, capture and record registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SCAN;
      marker <= 32'hFFFFFFFF;
      cur_id <= 8'h00;
      byte_index <= 9'd0;
      skip_count <= 17'd0;
      video_id <= pes_hdr_pkg::VIDEO_ID_RESET;
      audio_id <= pes_hdr_pkg::AUDIO_ID_RESET;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;

      // register writes
      if (cfg_valid && cfg_ready && cfg_index[7:1] == 7'd0) begin
        unique case (cfg_index[0])
          pes_hdr_pkg::CFG_VIDEO: video_id <= cfg_data;
          pes_hdr_pkg::CFG_AUDIO: audio_id <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_SCAN: if (accept) begin
          marker <= shifted;
          if (shifted[31:8] == pes_hdr_pkg::START_PREFIX) begin
            cur_id <= stream_byte;
            if (pes_hdr_pkg::id_class(stream_byte) != pes_hdr_pkg::ID_NONE) begin
              state <= S_COLLECT;
              byte_index <= 9'd0;
            end
          end
        end
        S_SKIP: if (accept) begin
          skip_count <= skip_count - 17'd1;
          if (skip_count == 17'd1) state <= S_SCAN;
        end
        S_COLLECT: if (accept) begin
          marker <= shifted;
          byte_index <= n;
          unique case (byte_index)
            9'd0: len_hi <= stream_byte;
            9'd1: len_lo <= stream_byte;
            9'd2: flg2 <= stream_byte;
            9'd3: flg3 <= stream_byte;
            9'd4: hl4 <= stream_byte;
            default: ;
          endcase
          // record fields shared by the complex cases
          stream_id <= cur_id;
          pes_length <= len_now;
          scramble_bits <= scr_now;
          mark_bad <= flg2[7:6] != 2'b10;
          header_length <= (byte_index == 9'd4) ? hlen_now : hlen_reg;
          packet_kind <= 1'b1;
          key_found <= 1'b0;
          block_number <= 24'd0;
          check_word <= 32'd0;
          marker_errors <= 3'd0;
          header_overflow <= 1'b0;
          encrypted <= enc_now;
          if (n > 9'd5) begin
            if (n >= hlen_reg) begin
              state <= S_FRD;
              flg_at <= OW'(5);
              at <= OW'(6);
              found <= 1'b0;
              blk <= 24'd0;
              chk <= 32'd0;
              errs <= 3'd0;
            end
          end else if (pes_hdr_pkg::id_class(cur_id) != pes_hdr_pkg::ID_COMPLEX) begin
            if (n == 9'd2) begin
              // simple packet: length only
              out_valid <= 1'b1;
              packet_kind <= 1'b0;
              header_length <= 9'd0;
              scramble_bits <= 2'd0;
              mark_bad <= 1'b0;
              encrypted <= 1'b0;
              marker <= 32'hFFFFFFFF;
              if (total > 17'd2) begin
                skip_count <= total - 17'd2;
                state <= S_SKIP;
              end else begin
                skip_count <= 17'd0;
                state <= S_SCAN;
              end
            end
          end else if (n == 9'd5) begin
            if (enc_now && flg3[0] && hlen_now > HB9) begin
              // header too long for the store, scanning resumes at once
              out_valid <= 1'b1;
              header_overflow <= 1'b1;
              skip_count <= 17'd0;
              state <= S_SCAN;
            end else if (!(enc_now && flg3[0] && hlen_now > 9'd5)) begin
              out_valid <= 1'b1;
              marker <= 32'hFFFFFFFF;
              if (total > 17'd5) begin
                skip_count <= total - 17'd5;
                state <= S_SKIP;
              end else begin
                skip_count <= 17'd0;
                state <= S_SCAN;
              end
            end
          end
        end
        S_FRD: state <= S_FLAG;
        S_FLAG: begin
          flag <= p;
          at <= at_a;
          if (p[7]) begin
            found <= 1'b1;
            errs <= 3'd0;
            k <= 4'd0;
            state <= S_URD;
          end else begin
            state <= S_POST;
          end
        end
        S_URD: state <= S_UUSE;
        // unpack one private data byte
        S_UUSE: begin
          unique case (k)
            4'd0: if (!p[7]) errs <= errs + 3'd1;
            4'd1: begin
              if (!p[6]) errs <= errs + 3'd1;
              blk[23:18] <= p[5:0];
            end
            4'd2: blk[17:10] <= p;
            4'd3: begin
              if (!p[5]) errs <= errs + 3'd1;
              blk[9:8] <= p[7:6];
              blk[7:3] <= p[4:0];
            end
            4'd4: begin
              if (!p[4]) errs <= errs + 3'd1;
              blk[2:0] <= p[7:5];
            end
            4'd11: chk[31:30] <= p[1:0];
            4'd12: chk[29:22] <= p;
            4'd13: begin
              if (!p[1]) errs <= errs + 3'd1;
              chk[21:16] <= p[7:2];
              chk[15] <= p[0];
            end
            4'd14: chk[14:7] <= p;
            4'd15: begin
              if (!p[0]) errs <= errs + 3'd1;
              chk[6:0] <= p[7:1];
            end
            default: ;
          endcase
          k <= k + 4'd1;
          state <= (k == 4'd15) ? S_POST : S_URD;
        end
        S_POST: begin
          if (flag[0]) begin
            flg_at <= at_b;
            at <= at_b + OW'(1);
            state <= S_FRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: if (!out_busy) begin
          out_valid <= 1'b1;
          encrypted <= 1'b1;
          key_found <= found;
          block_number <= blk;
          check_word <= chk;
          marker_errors <= errs;
          marker <= 32'hFFFFFFFF;
          if (total > {8'd0, hlen_reg}) begin
            skip_count <= total - {8'd0, hlen_reg};
            state <= S_SKIP;
          end else begin
            skip_count <= 17'd0;
            state <= S_SCAN;
          end
        end
        default: state <= S_SCAN;
      endcase
    end
  end

  // checks
  `PES_ASSERT_IMPLY(a_walk_stalls, clk, rst, walking, in_stall)
  `PES_ASSERT_IMPLY(a_skip_nonzero, clk, rst, state == S_SKIP, skip_count != 17'd0)
  `PES_ASSERT_IMPLY(a_key_complex, clk, rst, out_valid && key_found,
                    packet_kind && encrypted && !header_overflow)
  `PES_ASSERT_NEXT(a_walk_ends_record, clk, rst, state == S_DONE && !out_busy,
                   out_valid && state != S_DONE)

endmodule

/* tb/sv/pes_header_parser_tb.sv */
// self-checking testbench for the pes header parser: program stream bytes in,
// header records out, checked against a cycle-free model held in the bench
// depends on pes_hdr_pkg and the pes_header_parser rtl
module pes_header_parser_tb;

  localparam int HDR_BYTES = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 1200;

  typedef enum logic [1:0] {
    SCANNING,
    COLLECTING,
    SKIPPING
  } parse_phase_t;

  typedef struct {
    logic [7:0]  sid;
    logic        kind;
    logic [15:0] plen;
    logic [8:0]  hlen;
    logic [1:0]  scr;
    logic        bad;
    logic        enc;
    logic        found;
    logic [23:0] blk;
    logic [31:0] chk;
    logic [2:0]  errs;
    logic        ovf;
  } pes_record_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  stream_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  stream_id;
  logic        packet_kind;
  logic [15:0] pes_length;
  logic [8:0]  header_length;
  logic [1:0]  scramble_bits;
  logic        mark_bad;
  logic        encrypted;
  logic        key_found;
  logic [23:0] block_number;
  logic [31:0] check_word;
  logic [2:0]  marker_errors;
  logic        header_overflow;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'h00;
  logic [7:0]  cfg_data = 8'h00;

  pes_header_parser #(.HEADER_BYTES(HDR_BYTES)) dut (.*);

  always #5 clk = ~clk;

  // parser model state
  logic [31:0]  win_shift;
  parse_phase_t parse_ph;
  logic [7:0]   cur_sid;
  logic [8:0]   hdr_idx;
  logic [7:0]   hdr_mem [HDR_BYTES];
  logic [16:0]  skip_left;
  logic [7:0]   video_sid;
  logic [7:0]   audio_sid;

  pes_record_t  record_q [$];
  logic [7:0]   byte_q [$];
  int           n_errors = 0;
  int           n_records = 0;
  int           n_keys = 0;
  int           n_ovf = 0;
  int           n_enc = 0;
  int           n_bytes = 0;
  int           idle_cycles = 0;
  logic         took = 1'b0;
  int           in_gap = 0;
  int           out_gap = 0;
  int           quiet_left = 0;

  function automatic pes_hdr_pkg::id_class_t classify_sid(input logic [7:0] id);
    if (id < 8'hBB) return pes_hdr_pkg::ID_NONE;
    if (id == 8'hBD || (id >= 8'hC0 && id <= 8'hEF) || (id >= 8'hF3 && id <= 8'hF7) ||
        id == 8'hF9) return pes_hdr_pkg::ID_COMPLEX;
    return pes_hdr_pkg::ID_SIMPLE;
  endfunction

  function automatic logic [7:0] hdr_at(input int i, input int cnt);
    if (i < cnt && i < HDR_BYTES) return hdr_mem[i];
    return 8'h00;
  endfunction

  function automatic logic sid_matches(input logic [7:0] id);
    return id == video_sid || id == audio_sid;
  endfunction

  // header done: arm the payload skip
  task automatic end_packet(input int cnt);
    int total;
    total = int'({hdr_mem[0], hdr_mem[1]}) + 2;
    win_shift = '1;
    if (total > cnt) begin
      skip_left = 17'(total - cnt);
      parse_ph = SKIPPING;
    end else begin
      skip_left = '0;
      parse_ph = SCANNING;
    end
  endtask

  // complex record, optionally walking the extension flags
  task automatic complex_done(input int cnt, input bit walk);
    pes_record_t r;
    logic [7:0] f;
    logic [7:0] p [16];
    int flg_at;
    int at;
    r = '{default: '0};
    r.sid = cur_sid;
    r.kind = 1'b1;
    r.plen = {hdr_mem[0], hdr_mem[1]};
    r.hlen = 9'(5 + int'(hdr_mem[4]));
    r.scr = hdr_mem[2][5:4];
    r.bad = hdr_mem[2][7:6] != 2'b10;
    r.enc = sid_matches(cur_sid) && r.scr == 2'd3;
    if (walk) begin
      flg_at = 5;
      at = 6;
      for (int it = 0; it < 512; it++) begin
        f = hdr_at(flg_at, cnt);
        if (f[5]) at += 4;
        if (f[7]) begin
          for (int k = 0; k < 16; k++) p[k] = hdr_at(at + k, cnt);
          r.errs = 3'(int'(!p[0][7]) + int'(!p[1][6]) + int'(!p[3][5]) + int'(!p[4][4]) +
                      int'(!p[13][1]) + int'(!p[15][0]));
          r.blk = {p[1][5:0], p[2], p[3][7:6], p[3][4:0], p[4][7:5]};
          r.chk = {p[11][1:0], p[12], p[13][7:2], p[13][0], p[14], p[15][7:1]};
          r.found = 1'b1;
        end
        if (f[4]) at += 2;
        if (!f[0]) break;
        flg_at = at;
        at++;
      end
    end
    record_q.push_back(r);
    end_packet(cnt);
  endtask

  // advance the model by one accepted word
  task automatic parse_word(input logic [7:0] b);
    pes_record_t r;
    int n;
    int hl;
    logic [1:0] sc;
    case (parse_ph)
      SKIPPING: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) parse_ph = SCANNING;
      end
      SCANNING: begin
        win_shift = {win_shift[23:0], b};
        if (win_shift[31:8] == 24'h000001) begin
          cur_sid = b;
          if (classify_sid(b) != pes_hdr_pkg::ID_NONE) begin
            parse_ph = COLLECTING;
            hdr_idx = '0;
          end
        end
      end
      default: begin
        win_shift = {win_shift[23:0], b};
        if (hdr_idx < HDR_BYTES) hdr_mem[hdr_idx] = b;
        hdr_idx = hdr_idx + 9'd1;
        n = int'(hdr_idx);
        if (n > 5) begin
          if (n >= 5 + int'(hdr_mem[4])) complex_done(n, 1'b1);
        end else if (classify_sid(cur_sid) != pes_hdr_pkg::ID_COMPLEX) begin
          if (n == 2) begin
            r = '{default: '0};
            r.sid = cur_sid;
            r.plen = {hdr_mem[0], hdr_mem[1]};
            record_q.push_back(r);
            end_packet(2);
          end
        end else if (n == 5) begin
          sc = hdr_mem[2][5:4];
          hl = 5 + int'(hdr_mem[4]);
          if (sid_matches(cur_sid) && sc == 2'd3 && hdr_mem[3][0]) begin
            if (hl > HDR_BYTES) begin
              // header too long for the store: flag it, no skip
              r = '{default: '0};
              r.sid = cur_sid;
              r.kind = 1'b1;
              r.plen = {hdr_mem[0], hdr_mem[1]};
              r.hlen = 9'(hl);
              r.scr = sc;
              r.bad = hdr_mem[2][7:6] != 2'b10;
              r.enc = 1'b1;
              r.ovf = 1'b1;
              record_q.push_back(r);
              parse_ph = SCANNING;
              skip_left = '0;
            end else if (hl == 5) begin
              complex_done(5, 1'b1);
            end
          end else begin
            complex_done(5, 1'b0);
          end
        end
      end
    endcase
  endtask

  // build one pes packet; len_mode 0 normal, 1 any length (overflow only), 2 short
  task automatic add_pes(input logic [7:0] id, input logic [7:0] f1, input logic [7:0] f2,
                         input int hdl, input int pay, input int len_mode);
    logic [7:0] d [$];
    logic [7:0] fl;
    logic [15:0] len;
    int at;
    int offs [6] = '{0, 1, 3, 4, 13, 15};
    logic [7:0] masks [6] = '{8'h80, 8'h40, 8'h20, 8'h10, 8'h02, 8'h01};
    byte_q.push_back(8'h00);
    byte_q.push_back(8'h00);
    byte_q.push_back(8'h01);
    byte_q.push_back(id);
    if (classify_sid(id) != pes_hdr_pkg::ID_COMPLEX) begin
      len = 16'(pay);
      byte_q.push_back(len[15:8]);
      byte_q.push_back(len[7:0]);
      repeat (pay) byte_q.push_back(8'($urandom));
      return;
    end
    repeat (hdl) d.push_back(8'($urandom));
    if (hdl > 0) begin
      case ($urandom_range(0, 7))
        0, 7: fl = 8'h80;
        1: fl = 8'h81;
        2: fl = 8'hA0;
        3: fl = 8'h90;
        4: fl = 8'($urandom);
        5: fl = 8'hB1;
        default: fl = 8'h00;
      endcase
      d[0] = fl;
      at = fl[5] ? 5 : 1;
      // mostly well-formed private data markers
      if (fl[7])
        for (int k = 0; k < 6; k++)
          if (at + offs[k] < hdl && $urandom_range(0, 9) != 0) d[at + offs[k]] |= masks[k];
    end
    case (len_mode)
      1: len = 16'($urandom);
      2: len = 16'($urandom_range(0, 2 + hdl));
      default: len = 16'(3 + hdl + pay);
    endcase
    byte_q.push_back(len[15:8]);
    byte_q.push_back(len[7:0]);
    byte_q.push_back(f1);
    byte_q.push_back(f2);
    byte_q.push_back(8'(hdl));
    foreach (d[k]) byte_q.push_back(d[k]);
    if (len_mode == 0) repeat (pay) byte_q.push_back(8'($urandom));
  endtask

  function automatic logic [7:0] complex_sid();
    case ($urandom_range(0, 3))
      0: return 8'hBD;
      1: return 8'($urandom_range(8'hF3, 8'hF7));
      2: return 8'hF9;
      default: return 8'($urandom_range(8'hC0, 8'hEF));
    endcase
  endfunction

  function automatic logic [7:0] scrambled_flags();
    logic [1:0] top;
    logic [1:0] sc;
    top = ($urandom_range(0, 5) == 0) ? 2'($urandom) : 2'b10;
    sc = ($urandom_range(0, 4) == 0) ? 2'($urandom) : 2'b11;
    return {top, sc, 4'($urandom)};
  endfunction

  // random packet mix: mostly key-carrying packets, with noise
  task automatic fill_random(input int n_target);
    logic [7:0] id;
    int r;
    while (byte_q.size() < n_target) begin
      r = $urandom_range(0, 99);
      id = $urandom_range(0, 1) ? video_sid : audio_sid;
      if (r < 10) begin
        repeat ($urandom_range(1, 6)) byte_q.push_back(8'($urandom));
      end else if (r < 14) begin
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'($urandom));
      end else if (r < 25) begin
        add_pes(8'($urandom_range(8'hBB, 8'hFF)), 8'($urandom), 8'($urandom),
                $urandom_range(0, 10), $urandom_range(0, 8), 0);
      end else if (r < 42) begin
        add_pes(complex_sid(), 8'($urandom), 8'($urandom), $urandom_range(0, 10),
                $urandom_range(0, 6), 0);
      end else if (r < 85) begin
        add_pes(id, scrambled_flags(), 8'($urandom) | {7'd0, $urandom_range(0, 5) != 0},
                $urandom_range(0, 27), $urandom_range(0, 6), 0);
      end else if (r < 93) begin
        if (classify_sid(id) == pes_hdr_pkg::ID_COMPLEX)
          add_pes(id, {2'($urandom), 2'b11, 4'($urandom)}, 8'($urandom) | 8'h01,
                  $urandom_range(28, 45), 0, 1);
      end else begin
        add_pes(complex_sid(), scrambled_flags(), 8'($urandom), $urandom_range(0, 27), 0, 2);
      end
    end
  endtask

  // register write while the parser is idle
  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= 8'(idx);
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == pes_hdr_pkg::CFG_VIDEO) video_sid = val;
    else audio_sid = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || record_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // driver: next word at the falling edge, random gaps
  always @(negedge clk) begin
    logic        v;
    logic [7:0]  b;
    int          r;
    v = in_valid;
    b = stream_byte;
    if (rst) begin
      v = 1'b0;
    end else if (!in_valid || took) begin
      if (quiet_left > 0) quiet_left--;
      else if ($urandom_range(0, 199) == 0) quiet_left = $urandom_range(20, 120);
      if (in_gap > 0) begin
        in_gap--;
        v = 1'b0;
      end else if (byte_q.size() != 0) begin
        b = byte_q.pop_front();
        v = 1'b1;
        r = $urandom_range(0, 99);
        if (quiet_left > 0 || r < 60) in_gap = 0;
        else if (r < 93) in_gap = $urandom_range(1, 3);
        else in_gap = $urandom_range(8, 40);
      end else begin
        v = 1'b0;
      end
    end
    in_valid <= v;
    stream_byte <= b;
    // receiver stall pattern
    if (out_gap > 0) out_gap--;
    else if (quiet_left == 0 && $urandom_range(0, 5) == 0)
      out_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    out_stall <= out_gap > 0;
  end

  task automatic check_field(input string nm, input longint e, input longint a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, nm, e, a);
      n_errors++;
    end
  endtask

  // monitor: model update on accepted words, record check, watchdog
  always @(posedge clk) begin
    pes_record_t e;
    logic busy;
    busy = 1'b0;
    took <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        parse_word(stream_byte);
        n_bytes++;
        busy = 1'b1;
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (record_q.size() == 0) begin
          $display("%0t: unexpected record, stream id 0x%0h", $time, stream_id);
          n_errors++;
        end else begin
          e = record_q.pop_front();
          n_records++;
          n_keys += e.found;
          n_ovf += e.ovf;
          n_enc += e.enc;
          check_field("stream_id", e.sid, stream_id);
          check_field("packet_kind", e.kind, packet_kind);
          check_field("pes_length", e.plen, pes_length);
          check_field("header_length", e.hlen, header_length);
          check_field("scramble_bits", e.scr, scramble_bits);
          check_field("mark_bad", e.bad, mark_bad);
          check_field("encrypted", e.enc, encrypted);
          check_field("key_found", e.found, key_found);
          check_field("block_number", e.blk, block_number);
          check_field("check_word", e.chk, check_word);
          check_field("marker_errors", e.errs, marker_errors);
          check_field("header_overflow", e.ovf, header_overflow);
        end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d records still expected", $time, record_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // sequence: reset, directed packets, then random phases per register setting
  initial begin
    logic [7:0] vids [4] = '{8'h00, 8'hFF, 8'hBD, 8'h00};
    logic [7:0] aids [4] = '{8'hFF, 8'h00, 8'hF9, 8'h00};
    win_shift = '1;
    parse_ph = SCANNING;
    cur_sid = '0;
    hdr_idx = '0;
    skip_left = '0;
    video_sid = pes_hdr_pkg::VIDEO_ID_RESET;
    audio_sid = pes_hdr_pkg::AUDIO_ID_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: no-pes id, simple, empty simple, plain complex, bad marker,
    // key header, chained flags, overflow, short packet
    byte_q.push_back(8'hFF);
    byte_q.push_back(8'h00);
    byte_q.push_back(8'h00);
    byte_q.push_back(8'h01);
    byte_q.push_back(8'hBA);
    add_pes(8'hBE, 8'h00, 8'h00, 0, 3, 0);
    add_pes(8'hBB, 8'h00, 8'h00, 0, 0, 0);
    add_pes(8'hE0, 8'h80, 8'h00, 0, 1, 0);
    add_pes(8'hC0, 8'h70, 8'h01, 0, 0, 0);
    add_pes(8'hE0, 8'hB0, 8'h01, 20, 2, 0);
    add_pes(8'hC0, 8'hF0, 8'hFF, 27, 0, 0);
    add_pes(8'hE0, 8'hB0, 8'h01, 28, 0, 1);
    add_pes(8'hF9, 8'h80, 8'h00, 4, 0, 2);
    wait_drained();

    fill_random(300);
    wait_drained();
    for (int s = 0; s < 4; s++) begin
      if (s == 3) begin
        vids[s] = complex_sid();
        aids[s] = complex_sid();
      end
      write_reg(pes_hdr_pkg::CFG_VIDEO, vids[s]);
      write_reg(pes_hdr_pkg::CFG_AUDIO, aids[s]);
      fill_random(300);
      wait_drained();
    end

    $display("covered %0d stream words and %0d header records under 5 id settings",
             n_bytes, n_records);
    $display("  %0d encrypted, %0d with key sections, %0d header overflows",
             n_enc, n_keys, n_ovf);
    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
